FILE: rtl/crc8_cfr_pkg.sv
// ----------------------------------------------------------------------------
// crc8_cfr_pkg
// Types, constants and the CRC-8/MAXIM update shared by the frame receiver.
// ----------------------------------------------------------------------------
package crc8_cfr_pkg;

	localparam int unsigned MAX_FRAME  = 255;
	localparam int unsigned NUM_TGT    = 4;
	localparam logic [7:0]  CRC_POLY_R = 8'h8C;
	localparam logic [7:0]  OFFSET_MAX = 8'd252;
	localparam logic [7:0]  MIN_POS    = 8'd3;
	localparam logic [7:0]  HDR_BYTES  = 8'd2;
	localparam logic [7:0]  POS_MAX    = 8'hFF;
	localparam logic [7:0]  OVL_POS    = 8'(MAX_FRAME - 1);

	// register index, byte address is 4 * index
	typedef enum logic [2:0] {
		REG_CODE_ACCEL = 3'd0,
		REG_CODE_GYRO  = 3'd1,
		REG_CODE_MAG   = 3'd2,
		REG_CODE_PUB   = 3'd3,
		REG_SIZE_ACCEL = 3'd4,
		REG_SIZE_GYRO  = 3'd5,
		REG_SIZE_MAG   = 3'd6,
		REG_SIZE_PUB   = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		TGT_NONE  = 3'd0,
		TGT_ACCEL = 3'd1,
		TGT_GYRO  = 3'd2,
		TGT_MAG   = 3'd3,
		TGT_PUB   = 3'd4
	} target_t;

	typedef struct packed {
		logic [NUM_TGT-1:0][7:0] code;
		logic [NUM_TGT-1:0][7:0] size;
	} cfg_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       is_final;
	} in_item_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic [7:0] payload_offset;
		logic       payload_strobe;
		logic       frame_done;
		logic       frame_ok;
		target_t    target;
		logic [7:0] length_field;
	} res_t;

	// reflected crc-8, one byte, lsb first
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			v = v[0] ? ((v >> 1) ^ CRC_POLY_R) : (v >> 1);
		end
		return v;
	endfunction

endpackage

FILE: rtl/crc8_command_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// crc8_command_frame_receiver_unit
// Framed command receiver with CRC-8/MAXIM check and target decode.
// ----------------------------------------------------------------------------
// a byte accepted into the input register passes to the result register, and
// so to m_tvalid, once the result register is free or draining
// throughput: one byte per cycle unless m_tready stalls the result register;
// set by the combinational crc update and counter logic between the registers
// reset: arst_n clears frame state and valid flags; codes reset to 0..3,
// sizes to 0
module crc8_command_frame_receiver_unit
	import crc8_cfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte[7:0]
	input  logic        s_tlast,   // is_final
	output logic        m_tvalid,
	input  logic        m_tready,
	// payload_byte[7:0], payload_offset[15:8], frame_ok[16], target[19:17],
	// length_field[27:20], zero[31:28]
	output logic [31:0] m_tdata,
	output logic        m_tlast,   // frame_done
	output logic        m_tuser    // payload_strobe
);

	cfg_t     cfg;
	in_item_t in_item;
	in_item_t item;
	logic     fire;
	res_t     res;
	res_t     out_res;

	assign in_item.rx_byte  = s_tdata;
	assign in_item.is_final = s_tlast;

	crc8_cfr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crc8_cfr_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.item      (item),
		.fire      (fire),
		.res       (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	crc8_cfr_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.fire   (fire),
		.res    (res)
	);

	assign m_tdata = {4'd0, out_res.length_field, out_res.target, out_res.frame_ok,
		out_res.payload_offset, out_res.payload_byte};
	assign m_tlast = out_res.frame_done;
	assign m_tuser = out_res.payload_strobe;

endmodule

FILE: rtl/crc8_cfr_regs.sv
// ----------------------------------------------------------------------------
// crc8_cfr_regs
// APB register file holding the command codes and required sizes.
// ----------------------------------------------------------------------------
module crc8_cfr_regs
	import crc8_cfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;
	logic [7:0] rd_val;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.code <= {8'd3, 8'd2, 8'd1, 8'd0};
			cfg_q.size <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_CODE_ACCEL: cfg_q.code[0] <= pwdata[7:0];
				REG_CODE_GYRO:  cfg_q.code[1] <= pwdata[7:0];
				REG_CODE_MAG:   cfg_q.code[2] <= pwdata[7:0];
				REG_CODE_PUB:   cfg_q.code[3] <= pwdata[7:0];
				REG_SIZE_ACCEL: cfg_q.size[0] <= pwdata[7:0];
				REG_SIZE_GYRO:  cfg_q.size[1] <= pwdata[7:0];
				REG_SIZE_MAG:   cfg_q.size[2] <= pwdata[7:0];
				REG_SIZE_PUB:   cfg_q.size[3] <= pwdata[7:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CODE_ACCEL: rd_val = cfg_q.code[0];
			REG_CODE_GYRO:  rd_val = cfg_q.code[1];
			REG_CODE_MAG:   rd_val = cfg_q.code[2];
			REG_CODE_PUB:   rd_val = cfg_q.code[3];
			REG_SIZE_ACCEL: rd_val = cfg_q.size[0];
			REG_SIZE_GYRO:  rd_val = cfg_q.size[1];
			REG_SIZE_MAG:   rd_val = cfg_q.size[2];
			REG_SIZE_PUB:   rd_val = cfg_q.size[3];
			default:        rd_val = '0;
		endcase
	end

	assign prdata = {24'd0, rd_val};

endmodule

FILE: rtl/crc8_cfr_frame.sv
// ----------------------------------------------------------------------------
// crc8_cfr_frame
// Per-frame state (crc, position, header) and the result for one byte.
// ----------------------------------------------------------------------------
module crc8_cfr_frame
	import crc8_cfr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  in_item_t item,
	input  logic     fire,
	output res_t     res
);

	logic [7:0] crc_q;
	logic [7:0] pos_q;
	logic [7:0] cmd_q;
	logic [7:0] len_q;
	logic       overlong_q;

	logic [7:0] crc_nxt;
	logic [7:0] pos_diff;
	logic       hit;
	logic [1:0] tgt_idx;
	logic [7:0] size_sel;

	assign crc_nxt  = crc8_update(crc_q, item.rx_byte);
	assign pos_diff = pos_q - HDR_BYTES;

	// first matching code wins
	always_comb begin
		hit     = 1'b0;
		tgt_idx = '0;
		for (int t = NUM_TGT - 1; t >= 0; t--) begin
			if (cmd_q == cfg.code[t]) begin
				hit     = 1'b1;
				tgt_idx = 2'(t);
			end
		end
	end

	assign size_sel = cfg.size[tgt_idx];

	always_comb begin
		res                = '0;
		res.payload_byte   = item.rx_byte;
		res.target         = TGT_NONE;
		if (!item.is_final) begin
			if (pos_q >= HDR_BYTES) begin
				res.payload_strobe = 1'b1;
				res.payload_offset = (pos_diff > OFFSET_MAX) ? OFFSET_MAX : pos_diff;
			end
		end else begin
			res.frame_done   = 1'b1;
			res.length_field = len_q;
			if (hit) res.target = target_t'({1'b0, tgt_idx} + 3'd1);
			res.frame_ok = (crc_q == item.rx_byte) && (pos_q >= MIN_POS) && hit &&
				!overlong_q && (len_q == size_sel) && (len_q <= pos_diff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= '0;
			pos_q      <= '0;
			cmd_q      <= '0;
			len_q      <= '0;
			overlong_q <= 1'b0;
		end else if (fire) begin
			if (item.is_final) begin
				crc_q      <= '0;
				pos_q      <= '0;
				cmd_q      <= '0;
				len_q      <= '0;
				overlong_q <= 1'b0;
			end else begin
				crc_q <= crc_nxt;
				if (pos_q == 8'd0) cmd_q <= item.rx_byte;
				if (pos_q == 8'd1) len_q <= item.rx_byte;
				if (pos_q >= OVL_POS) overlong_q <= 1'b1;
				if (pos_q != POS_MAX) pos_q <= pos_q + 8'd1;
			end
		end
	end

	a_ok_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.frame_ok |-> res.frame_done && res.target != TGT_NONE)
		else $error("verdict ok outside a final byte or without a target");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.is_final |=> pos_q == 8'd0 && crc_q == 8'd0 && !overlong_q)
		else $error("frame state not cleared after final byte");

	a_overlong_pos: assert property (@(posedge clk) disable iff (!arst_n)
		overlong_q |-> pos_q > OVL_POS || pos_q == OVL_POS)
		else $error("overlong set below the frame limit");

	a_strobe_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(res.payload_strobe && res.frame_done))
		else $error("payload strobe on a final byte");

endmodule

FILE: rtl/crc8_cfr_pipe.sv
// ----------------------------------------------------------------------------
// crc8_cfr_pipe
// Input register and result register with stream back-pressure.
// ----------------------------------------------------------------------------
module crc8_cfr_pipe
	import crc8_cfr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	output in_item_t item,
	output logic     fire,
	input  res_t     res,
	output logic     out_valid,
	input  logic     out_ready,
	output res_t     out_res
);

	logic     valid_s1;
	in_item_t item_s1;
	logic     valid_s2;
	res_t     res_s2;
	logic     advance;

	// stage 1 moves on whenever the result register is free or being drained
	assign advance  = !valid_s2 || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance)  valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_s1 <= in_item;
		if (fire)                 res_s2  <= res;
	end

	assign out_valid = valid_s2;
	assign out_res   = res_s2;

endmodule
